>>> rtl/c3ef_pkg.sv
// Shared types, constants and helper functions for the 3x3 edge filter.
package c3ef_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 6;
  localparam int COEF_BITS_MAX = 7;
  localparam int KWORD_MAX     = 9 * COEF_BITS_MAX;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_KERNEL_WORDS   = 3'd2;
  localparam logic [2:0] REG_EDGE_MODE      = 3'd3;
  localparam logic [2:0] REG_EDGE_THRESHOLD = 3'd4;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Reset values
  localparam int          WIDTH_RESET  = 1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd1024;
  localparam logic        MODE_RESET   = 1'b0;
  localparam logic [7:0]  THRESH_RESET = 8'd26;
  localparam int          KERNEL_RESET [9] = '{0, -1, 0, -1, 5, -1, 0, -1, 0};

  // Gray weights, sum 256, rounded half up
  localparam int GRAY_R     = 77;
  localparam int GRAY_G     = 150;
  localparam int GRAY_B     = 29;
  localparam int GRAY_ROUND = 128;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } result_t;

  // Border flags of one output position
  typedef struct packed {
    logic row_first;
    logic row_last;
    logic col_first;
    logic col_last;
    logic eof;
  } pos_flags_t;

  function automatic logic [KWORD_MAX-1:0] kernel_reset(input int bits);
    logic [KWORD_MAX-1:0] w;
    logic [7:0]           c;
    w = '0;
    for (int k = 0; k < 9; k++) begin
      c = 8'(KERNEL_RESET[k]);
      for (int b = 0; b < bits; b++) begin
        w[k*bits+b] = c[b];
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] gray8(input logic [23:0] px);
    logic [15:0] s;
    s = 16'(GRAY_R * int'(px[23:16]) + GRAY_G * int'(px[15:8])
            + GRAY_B * int'(px[7:0]) + GRAY_ROUND);
    return s[15:8];
  endfunction

endpackage

>>> rtl/conv3x3_edge_filter_top.sv
// Streaming 3x3 convolution with replicated borders, RGB filter or gray edge threshold.
//
// Usage:
//   Pixels enter in raster order on the pixel channel (valid/stall), one
//   transaction per clock at most. kind = drain marks a tick that flushes the
//   tail of a fully received frame; ticks at any other time are taken and dropped.
//   Results leave on the result channel (valid/stall); each one belongs to the
//   pixel position image_width+1 slots earlier, so output lags one row plus one
//   pixel. end_of_frame flags the last result of a frame.
//   Throughput is one transaction per cycle while pixel_stall is low; the result
//   a transaction releases passes through memory read, window shift, multiply, then
//   sum into the output register.
//   The line buffers have one read and one write port, used once per slot, which
//   is what fixes that rate.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
//   Reset clears counters, window and pipeline and loads the default config;
//   line buffers are not cleared (unwritten entries only feed discarded rows).
//   When the receiver stalls, the result holds and a skid register takes one more
//   result; pixel_stall rises only once that skid register is full.
module conv3x3_edge_filter_top #(
  parameter int MAX_WIDTH = c3ef_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = c3ef_pkg::COEF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  output logic                     pixel_stall,
  input  c3ef_pkg::pixel_t         pixel,
  output logic                     result_valid,
  input  logic                     result_stall,
  output c3ef_pkg::result_t        result,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [9*COEF_BITS-1:0]   cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 3);
  localparam int KW = 9 * COEF_BITS;
  localparam int PW = COEF_BITS + 9;
  localparam int SW = PW + 4;
  localparam int W_RESET = (MAX_WIDTH < c3ef_pkg::WIDTH_RESET) ? MAX_WIDTH
                                                               : c3ef_pkg::WIDTH_RESET;

  // ---------------------------------------------------------------------------
  // Configuration; width and height are stored already saturated
  // ---------------------------------------------------------------------------
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [KW-1:0] kernel;
  logic          edge_mode;
  logic [7:0]    edge_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff          <= WW'(W_RESET);
      h_eff          <= c3ef_pkg::HEIGHT_RESET;
      kernel         <= KW'(c3ef_pkg::kernel_reset(COEF_BITS));
      edge_mode      <= c3ef_pkg::MODE_RESET;
      edge_threshold <= c3ef_pkg::THRESH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        c3ef_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data[10:0] == 11'd0) begin
            w_eff <= WW'(1);
          end else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH)) begin
            w_eff <= WW'(MAX_WIDTH);
          end else begin
            w_eff <= WW'(cfg_data[10:0]);
          end
        end
        c3ef_pkg::REG_IMAGE_HEIGHT: begin
          h_eff <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
        end
        c3ef_pkg::REG_KERNEL_WORDS:   kernel         <= cfg_data;
        c3ef_pkg::REG_EDGE_MODE:      edge_mode      <= cfg_data[0];
        c3ef_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless the skid register is full
  // ---------------------------------------------------------------------------
  logic skid_valid;
  logic adv;
  logic accept;

  assign adv         = !skid_valid;
  assign pixel_stall = skid_valid;
  assign accept      = pixel_valid && !pixel_stall;

  // ---------------------------------------------------------------------------
  // Stage 0: position counters and slot bookkeeping
  // ---------------------------------------------------------------------------
  logic [WW-1:0] in_column, in_column_next;
  logic [15:0]   in_row, in_row_next;
  logic [WW-1:0] out_col, out_col_next;
  logic [15:0]   out_row, out_row_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] pend, pend_next;
  logic [AW-1:0] drain_col, drain_col_next;
  logic          drain_any, drain_any_next;

  logic                 slot, has_pix, fire, restart, wrap_col;
  logic [AW-1:0]        rd_addr;
  c3ef_pkg::pos_flags_t flags;
  logic [WW-1:0]        col_w, oc;
  logic [16:0]          row_a;
  logic [15:0]          row_w, orow;
  logic [WW:0]          col_inc;
  logic [FW-1:0]        fill_a, pend_a;

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    fill_next      = fill;
    pend_next      = pend;
    drain_col_next = drain_col;
    drain_any_next = drain_any;
    slot           = 1'b0;
    has_pix        = 1'b0;
    fire           = 1'b0;
    rd_addr        = drain_col;

    // Wrap positions left past the frame size
    wrap_col = in_column >= w_eff;
    col_w    = wrap_col ? '0 : in_column;
    row_a    = wrap_col ? {1'b0, in_row} + 17'd1 : {1'b0, in_row};
    row_w    = (row_a >= {1'b0, h_eff}) ? 16'd0 : row_a[15:0];
    restart  = (row_w == 16'd0) && (col_w == '0) && drain_any;
    col_inc  = {1'b0, col_w} + (WW+1)'(1);
    fill_a   = fill;
    pend_a   = pend;
    oc       = out_col;
    orow     = out_row;

    if (accept && pixel.kind == c3ef_pkg::KIND_PIXEL) begin
      slot    = 1'b1;
      has_pix = 1'b1;
      rd_addr = col_w[AW-1:0];
      // Drop the rest of a partly drained tail
      if (restart) begin
        fill_a         = '0;
        pend_a         = '0;
        oc             = '0;
        orow           = 16'd0;
        drain_col_next = '0;
        drain_any_next = 1'b0;
      end
      pend_a    = pend_a + FW'(1);
      fire      = 32'(fill_a) >= 32'(w_eff) + 32'd1;
      pend_next = fire ? pend_a - FW'(1) : pend_a;
      fill_next = fire ? fill_a : fill_a + FW'(1);
      if (col_inc >= {1'b0, w_eff}) begin
        in_column_next = '0;
        in_row_next    = (32'(row_w) + 32'd1 >= 32'(h_eff)) ? 16'd0 : row_w + 16'd1;
      end else begin
        in_column_next = col_inc[WW-1:0];
        in_row_next    = row_w;
      end
    end else if (accept && pixel.kind == c3ef_pkg::KIND_DRAIN && in_row == 16'd0 &&
                 in_column == '0 && pend != '0) begin
      slot      = 1'b1;
      rd_addr   = drain_col;
      fire      = 32'(fill) >= 32'(w_eff) + 32'd1;
      pend_a    = fire ? pend - FW'(1) : pend;
      pend_next = pend_a;
      fill_next = fire ? fill : fill + FW'(1);
      if (pend_a == '0) begin
        fill_next      = '0;
        drain_col_next = '0;
        drain_any_next = 1'b0;
      end else begin
        drain_any_next = 1'b1;
        drain_col_next = (32'(drain_col) + 32'd1 >= 32'(w_eff)) ? '0 : drain_col + AW'(1);
      end
    end

    flags.row_first = orow == 16'd0;
    flags.row_last  = 32'(orow) + 32'd1 >= 32'(h_eff);
    flags.col_first = oc == '0;
    flags.col_last  = 32'(oc) + 32'd1 >= 32'(w_eff);
    // A position already past the last row also closes the frame
    flags.eof       = (32'(orow) >= 32'(h_eff)) || (flags.row_last && flags.col_last);

    out_col_next = oc;
    out_row_next = orow;
    if (fire) begin
      if (flags.eof) begin
        out_col_next = '0;
        out_row_next = 16'd0;
      end else if (flags.col_last) begin
        out_col_next = '0;
        out_row_next = orow + 16'd1;
      end else begin
        out_col_next = oc + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= 16'd0;
      out_col   <= '0;
      out_row   <= 16'd0;
      fill      <= '0;
      pend      <= '0;
      drain_col <= '0;
      drain_any <= 1'b0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
      fill      <= fill_next;
      pend      <= pend_next;
      drain_col <= drain_col_next;
      drain_any <= drain_any_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: read at slot entry, write back one stage later
  // ---------------------------------------------------------------------------
  logic [23:0] upper_mem  [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] up_q, mid_q, fwd_up, fwd_mid;
  logic        fwd_hit;

  logic                 s1_slot, s1_pix, s1_emit;
  logic [23:0]          s1_rgb;
  logic [AW-1:0]        s1_x;
  c3ef_pkg::pos_flags_t s1_flags;
  logic [23:0]          s1_top, s1_mid, s1_bot;

  assign s1_top = fwd_hit ? fwd_up : up_q;
  assign s1_mid = fwd_hit ? fwd_mid : mid_q;
  assign s1_bot = s1_pix ? s1_rgb : 24'd0;

  always_ff @(posedge clk) begin
    if (adv) begin
      up_q    <= upper_mem[rd_addr];
      mid_q   <= middle_mem[rd_addr];
      // Same column written this edge: take the data being written
      fwd_hit <= s1_slot && s1_pix && (s1_x == rd_addr);
      fwd_up  <= s1_mid;
      fwd_mid <= s1_rgb;
      if (s1_slot && s1_pix) begin
        upper_mem[s1_x]  <= s1_mid;
        middle_mem[s1_x] <= s1_rgb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_slot <= 1'b0;
      s1_emit <= 1'b0;
    end else if (adv) begin
      s1_slot <= slot;
      s1_emit <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix   <= has_pix;
      s1_rgb   <= {pixel.red, pixel.green, pixel.blue};
      s1_x     <= rd_addr;
      s1_flags <= flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> window: shift in the new column with its gray values
  // ---------------------------------------------------------------------------
  logic [23:0] win_rgb  [3][3];
  logic [7:0]  win_gray [3][3];
  logic [23:0] col_rgb  [3];

  assign col_rgb[0] = s1_top;
  assign col_rgb[1] = s1_mid;
  assign col_rgb[2] = s1_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_rgb[i][j]  <= 24'd0;
          win_gray[i][j] <= 8'd0;
        end
      end
    end else if (adv && s1_slot) begin
      for (int i = 0; i < 3; i++) begin
        win_rgb[i][0]  <= win_rgb[i][1];
        win_rgb[i][1]  <= win_rgb[i][2];
        win_rgb[i][2]  <= col_rgb[i];
        win_gray[i][0] <= win_gray[i][1];
        win_gray[i][1] <= win_gray[i][2];
        win_gray[i][2] <= c3ef_pkg::gray8(col_rgb[i]);
      end
    end
  end

  logic                 s2_emit;
  c3ef_pkg::pos_flags_t s2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else if (adv) begin
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flags <= s1_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: border replication and 27 coefficient products
  // ---------------------------------------------------------------------------
  logic [23:0]           sel_rgb  [3][3];
  logic [7:0]            sel_gray [3][3];
  logic [23:0]           tap_rgb  [3][3];
  logic [7:0]            tap_gray [3][3];
  logic signed [PW-1:0]  prod     [3][9];
  logic signed [PW-1:0]  s3_prod  [3][9];
  logic [7:0]            lane_v   [3];
  logic signed [COEF_BITS-1:0] cf;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sel_rgb[0][j]  = s2_flags.row_first ? win_rgb[1][j]  : win_rgb[0][j];
      sel_gray[0][j] = s2_flags.row_first ? win_gray[1][j] : win_gray[0][j];
      sel_rgb[1][j]  = win_rgb[1][j];
      sel_gray[1][j] = win_gray[1][j];
      sel_rgb[2][j]  = s2_flags.row_last ? win_rgb[1][j]  : win_rgb[2][j];
      sel_gray[2][j] = s2_flags.row_last ? win_gray[1][j] : win_gray[2][j];
    end
    for (int i = 0; i < 3; i++) begin
      tap_rgb[i][0]  = s2_flags.col_first ? sel_rgb[i][1]  : sel_rgb[i][0];
      tap_gray[i][0] = s2_flags.col_first ? sel_gray[i][1] : sel_gray[i][0];
      tap_rgb[i][1]  = sel_rgb[i][1];
      tap_gray[i][1] = sel_gray[i][1];
      tap_rgb[i][2]  = s2_flags.col_last ? sel_rgb[i][1]  : sel_rgb[i][2];
      tap_gray[i][2] = s2_flags.col_last ? sel_gray[i][1] : sel_gray[i][2];
    end
    cf = '0;
    for (int l = 0; l < 3; l++) begin
      lane_v[l] = 8'd0;
    end
    for (int k = 0; k < 9; k++) begin
      cf        = $signed(kernel[k*COEF_BITS +: COEF_BITS]);
      // Gray mode runs the gray plane through lane 0 only
      lane_v[0] = edge_mode ? tap_gray[k/3][k%3] : tap_rgb[k/3][k%3][23:16];
      lane_v[1] = tap_rgb[k/3][k%3][15:8];
      lane_v[2] = tap_rgb[k/3][k%3][7:0];
      for (int l = 0; l < 3; l++) begin
        prod[l][k] = $signed({1'b0, lane_v[l]}) * cf;
      end
    end
  end

  logic s3_emit, s3_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else if (adv) begin
      s3_emit <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_eof  <= s2_flags.eof;
      s3_prod <= prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, clamp, optional threshold
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] clamp8(input logic signed [SW-1:0] v);
    if (v[SW-1]) begin
      return 8'd0;
    end else if (|v[SW-2:8]) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  logic signed [SW-1:0] lane_sum [3];
  logic [7:0]           lane_c   [3];
  logic [7:0]           edge_v;
  c3ef_pkg::result_t    res;
  logic                 res_take;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_sum[l] = '0;
      for (int k = 0; k < 9; k++) begin
        lane_sum[l] = lane_sum[l] + SW'(s3_prod[l][k]);
      end
      lane_c[l] = clamp8(lane_sum[l]);
    end
    edge_v = (lane_c[0] > edge_threshold) ? 8'd255 : 8'd0;
    res.out_red      = edge_mode ? edge_v : lane_c[0];
    res.out_green    = edge_mode ? edge_v : lane_c[1];
    res.out_blue     = edge_mode ? edge_v : lane_c[2];
    res.end_of_frame = s3_eof;
  end

  assign res_take = s3_emit && adv;

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  c3ef_pkg::result_t out_data, skid_data;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result_stall) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_take;
      end
    end else if (!out_valid) begin
      out_valid <= res_take;
    end else if (res_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !result_stall) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (!out_valid) begin
      out_data <= res;
    end else if (res_take) begin
      skid_data <= res;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output result");

  a_stalled_result_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_stall && res_take) |=> skid_valid)
    else $error("result lost while output was stalled");

  a_drain_has_pending: assert property (@(posedge clk) disable iff (rst)
    drain_any |-> (pend != '0))
    else $error("drain in progress with nothing pending");

endmodule
